/* sv/dcf77_time_signal_decoder_assert.svh */
// Assertion macros for the time signal decoder
`ifndef DCF77_TIME_SIGNAL_DECODER_ASSERT_SVH
`define DCF77_TIME_SIGNAL_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dcf_pkg.sv */
package dcf_pkg;

  localparam int FRAME_W = 61;
  localparam int POS_W   = 6;
  localparam int CIDX_W  = 3;
  localparam int CFG_W   = 16;

  localparam logic [CIDX_W-1:0] CFG_MIN_EDGE  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_MIN_PULSE = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_MAX_PULSE = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_ONE_THR   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_GAP_LOW   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_GAP_HIGH  = 3'd5;

  localparam logic [1:0] ST_RISE  = 2'd0;
  localparam logic [1:0] ST_BIT   = 2'd1;
  localparam logic [1:0] ST_SOON  = 2'd2;
  localparam logic [1:0] ST_WIDTH = 2'd3;

  localparam logic [POS_W-1:0] POS_LEAP_ANN  = 6'd19;
  localparam logic [POS_W-1:0] POS_LEAP_SEC  = 6'd59;
  localparam logic [POS_W-1:0] POS_LAST      = 6'd59;
  localparam logic [POS_W-1:0] POS_LEAP_LAST = 6'd60;
  localparam logic [7:0]       LAST_MINUTE   = 8'd59;
  localparam logic [7:0]       CENTURY_YEAR  = 8'd100;
  localparam logic [11:0]      YEAR_BASE     = 12'd2000;

  typedef struct packed {
    logic [CFG_W-1:0] min_edge_period_ms;
    logic [CFG_W-1:0] min_pulse_ms;
    logic [CFG_W-1:0] max_pulse_ms;
    logic [CFG_W-1:0] one_threshold_ms;
    logic [CFG_W-1:0] gap_low_ms;
    logic [CFG_W-1:0] gap_high_ms;
  } dcf_cfg_t;

  typedef struct packed {
    logic        parity_ok;
    logic [7:0]  minute;
    logic [7:0]  hour;
    logic [7:0]  day;
    logic [7:0]  weekday;
    logic [7:0]  month;
    logic [11:0] year;
    logic        summer;
    logic        leap_year;
  } dcf_date_t;

  // weights 1,2,4,8 on the low nibble, 10,20,40,80 on the high nibble
  function automatic logic [7:0] bcd_value(input logic [7:0] v);
    logic [7:0] tens;
    tens = {4'b0, v[7:4]};
    return {4'b0, v[3:0]} + (tens << 3) + (tens << 1);
  endfunction

endpackage

/* sv/dcf_cfg_regs.sv */
module dcf_cfg_regs
  import dcf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [CIDX_W-1:0]        wr_index,
  input  logic [CFG_W-1:0]         wr_data,
  output dcf_cfg_t                 cfg
);

  dcf_cfg_t cfg_r;
  dcf_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_MIN_EDGE:  cfg_nxt.min_edge_period_ms = wr_data;
        CFG_MIN_PULSE: cfg_nxt.min_pulse_ms       = wr_data;
        CFG_MAX_PULSE: cfg_nxt.max_pulse_ms       = wr_data;
        CFG_ONE_THR:   cfg_nxt.one_threshold_ms   = wr_data;
        CFG_GAP_LOW:   cfg_nxt.gap_low_ms         = wr_data;
        CFG_GAP_HIGH:  cfg_nxt.gap_high_ms        = wr_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_edge_period_ms <= 16'd900;
      cfg_r.min_pulse_ms       <= 16'd70;
      cfg_r.max_pulse_ms       <= 16'd230;
      cfg_r.one_threshold_ms   <= 16'd170;
      cfg_r.gap_low_ms         <= 16'd1900;
      cfg_r.gap_high_ms        <= 16'd2100;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/dcf_frame_dec.sv */
module dcf_frame_dec
  import dcf_pkg::*;
(
  input  logic [FRAME_W-1:0] frame,
  output dcf_date_t          date
);

  logic [7:0] year_bcd;

  always_comb begin
    year_bcd       = bcd_value(frame[57:50]);
    date.parity_ok = !(^frame[28:21]) && !(^frame[35:29]) && !(^frame[58:36]);
    date.minute    = bcd_value({1'b0, frame[27:21]});
    date.hour      = bcd_value({2'b0, frame[34:29]});
    date.day       = bcd_value({2'b0, frame[41:36]});
    date.weekday   = bcd_value({5'b0, frame[44:42]});
    date.month     = bcd_value({3'b0, frame[49:45]});
    date.year      = {4'b0, year_bcd} + YEAR_BASE;
    date.summer    = frame[17];
    // years 2000..2165: divisible by 4, except 2100
    date.leap_year = (year_bcd[1:0] == 2'b00) && (year_bcd != CENTURY_YEAR);
  end

endmodule

/* sv/dcf77_time_signal_decoder.sv */
// Time signal decoder for a 77.5 kHz long-wave time code receiver.
// Input channel: one word per signal edge, in_level (1 rising, 0 falling)
// and in_time_ms, a free-running 32-bit millisecond timestamp.
// Output channel: one word per input word, carrying the date registers,
// the validity flag, the edge status and a minute-complete flag.
// Config channel: cfg_index selects one of six 16-bit thresholds; writes
// are always accepted (cfg_ready tied high), indexes above five ignored.
// A word accepted into the input register passes through the compute stage
// into the output register. Throughput: one word per cycle while out_ready
// is high, set by the single compute stage between the two registers.
// The output register holds its word while out_ready is low; the input
// register still takes one more word, then in_ready drops until the output
// frees up.
// Reset: thresholds return to 900/70/230/170/1900/2100 ms, frame buffer and
// timestamps clear, the internal date fields hold 255 (year 255) with summer
// and leap flags set, the stored validity flag is low; out_valid is low.
module dcf77_time_signal_decoder
  import dcf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_level,
  input  logic [31:0]         in_time_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_date_valid,
  output logic [7:0]          out_minute,
  output logic [7:0]          out_hour,
  output logic [7:0]          out_day,
  output logic [7:0]          out_weekday,
  output logic [7:0]          out_month,
  output logic [11:0]         out_year,
  output logic                out_summer_time,
  output logic                out_leap_year,
  output logic [1:0]          out_edge_status,
  output logic                out_minute_done,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  `include "dcf77_time_signal_decoder_assert.svh"

  dcf_cfg_t  cfg;
  dcf_date_t dec;

  logic        in_valid_r;
  logic        in_level_r;
  logic [31:0] in_time_r;
  logic        out_valid_r;

  logic [31:0]        lead_r, lead_nxt;
  logic [31:0]        prev_r, prev_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               la_r, la_nxt;
  logic               ls_r, ls_nxt;
  logic               sig_r, sig_nxt;
  dcf_date_t          date_r, date_nxt;
  logic [1:0]         status_nxt;
  logic               done_nxt;

  logic               adv;
  logic               fire;
  logic [31:0]        period;
  logic [31:0]        width;
  logic               too_soon;
  logic               bad_width;
  logic               bit_val;
  logic               is_minute;
  logic               take;
  logic [FRAME_W-1:0] frame_base;
  logic [POS_W-1:0]   pos_base;
  logic [POS_W-1:0]   pos_inc;

  dcf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dcf_frame_dec u_dec (
    .frame (frame_r),
    .date  (dec)
  );

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || adv;
  assign fire      = in_valid_r && adv;
  assign out_valid = out_valid_r;

  always_comb begin
    period    = lead_r - prev_r;
    width     = in_time_r - lead_r;
    too_soon  = period < {16'b0, cfg.min_edge_period_ms};
    bad_width = (width < {16'b0, cfg.min_pulse_ms}) || (width > {16'b0, cfg.max_pulse_ms});
    bit_val   = !(width < {16'b0, cfg.one_threshold_ms});
    is_minute = (period > {16'b0, cfg.gap_low_ms}) && (period < {16'b0, cfg.gap_high_ms});
    take      = dec.parity_ok &&
                ((pos_r == POS_LAST) ||
                 ((pos_r == POS_LEAP_LAST) && la_r && (date_r.minute == LAST_MINUTE) &&
                  !ls_r));

    lead_nxt   = lead_r;
    prev_nxt   = prev_r;
    frame_nxt  = frame_r;
    pos_nxt    = pos_r;
    la_nxt     = la_r;
    ls_nxt     = ls_r;
    sig_nxt    = sig_r;
    date_nxt   = date_r;
    status_nxt = ST_RISE;
    done_nxt   = 1'b0;
    frame_base = frame_r;
    pos_base   = pos_r;
    pos_inc    = pos_r;

    if (in_level_r) begin
      lead_nxt = in_time_r;
    end else if (too_soon || bad_width) begin
      status_nxt = too_soon ? ST_SOON : ST_WIDTH;
      prev_nxt   = lead_r;
    end else begin
      status_nxt = ST_BIT;
      prev_nxt   = lead_r;
      if (is_minute) begin
        done_nxt   = 1'b1;
        sig_nxt    = take;
        frame_base = '0;
        pos_base   = '0;
        if (take) begin
          date_nxt = dec;
        end
      end
      frame_nxt = frame_base | (FRAME_W'(bit_val) << pos_base);
      if (pos_base == POS_LEAP_ANN) begin
        la_nxt = bit_val;
      end
      if (pos_base == POS_LEAP_SEC) begin
        ls_nxt = bit_val;
      end
      pos_inc = pos_base + POS_W'(1);
      if ((pos_inc > POS_LAST) && !((pos_inc == POS_LEAP_LAST) && la_nxt)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lead_r      <= '0;
      prev_r      <= '0;
      frame_r     <= '0;
      pos_r       <= '0;
      la_r        <= 1'b0;
      ls_r        <= 1'b0;
      sig_r       <= 1'b0;
      date_r      <= '{parity_ok: 1'b0, minute: 8'd255, hour: 8'd255, day: 8'd255,
                       weekday: 8'd255, month: 8'd255, year: 12'd255,
                       summer: 1'b1, leap_year: 1'b1};
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        lead_r  <= lead_nxt;
        prev_r  <= prev_nxt;
        frame_r <= frame_nxt;
        pos_r   <= pos_nxt;
        la_r    <= la_nxt;
        ls_r    <= ls_nxt;
        sig_r   <= sig_nxt;
        date_r  <= date_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_level_r <= in_level;
      in_time_r  <= in_time_ms;
    end
    if (fire) begin
      out_date_valid  <= sig_nxt;
      out_minute      <= date_nxt.minute;
      out_hour        <= date_nxt.hour;
      out_day         <= date_nxt.day;
      out_weekday     <= date_nxt.weekday;
      out_month       <= date_nxt.month;
      out_year        <= date_nxt.year;
      out_summer_time <= date_nxt.summer;
      out_leap_year   <= date_nxt.leap_year;
      out_edge_status <= status_nxt;
      out_minute_done <= done_nxt;
    end
  end

  `DCF_ASSERT_NOW(a_done_is_bit, out_valid_r && out_minute_done,
    out_edge_status == ST_BIT, "minute_done without an accepted bit")
  `DCF_ASSERT_NOW(a_pos_leap, pos_r == POS_LEAP_LAST, la_r,
    "bit position 60 without leap announcement")
  `DCF_ASSERT_NOW(a_pos_range, 1'b1, pos_r <= POS_LEAP_LAST,
    "bit position beyond 60")
  `DCF_ASSERT_NEXT(a_rise_status, fire && in_level_r,
    out_edge_status == ST_RISE && !out_minute_done, "rising edge reported wrong")

endmodule
